### rtl/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants of the source tokenizer
// Token kinds, scan modes, character codes and character class functions.
// ----------------------------------------------------------------------------
package bst_pkg;

	// Character codes the scanner looks for.
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	localparam logic [7:0] CHAR_LT    = 8'h3C;
	localparam logic [7:0] CHAR_GT    = 8'h3E;
	localparam logic [7:0] CHAR_EQ    = 8'h3D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	// Depth of the output queue and the width of its fill count.
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_NUM  = 3'd0,
		KIND_WORD = 3'd1,
		KIND_STR  = 3'd2,
		KIND_OP   = 3'd3,
		KIND_CHAR = 3'd4,
		KIND_END  = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_NUM  = 3'd1,
		MODE_WORD = 3'd2,
		MODE_STR  = 3'd3,
		MODE_LT   = 3'd4,
		MODE_GT   = 3'd5
	} mode_t;

	// One token as it leaves the block.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] first;
		logic [15:0] after;
		logic        last;
	} token_t;

	// Up to two tokens produced by one byte, in output order.
	typedef struct packed {
		logic   v0;
		logic   v1;
		token_t t0;
		token_t t1;
	} push_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
	endfunction

endpackage

### rtl/bst_if.sv
// ----------------------------------------------------------------------------
// bst_if: channel interfaces of the source tokenizer
// A byte channel for source text and a token channel for results.
// ----------------------------------------------------------------------------
interface bst_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface bst_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [15:0] token_first;
	logic [15:0] token_after;
	logic        final_of_run;

	modport source (output valid, output token_kind, output token_first,
		output token_after, output final_of_run, input ready);
	modport sink (input valid, input token_kind, input token_first,
		input token_after, input final_of_run, output ready);
endinterface

### rtl/bst_scan.sv
// ----------------------------------------------------------------------------
// bst_scan: scanner stage of the source tokenizer
// Registers one byte, updates the scan state and produces up to two tokens.
// ----------------------------------------------------------------------------
module bst_scan #(
	parameter int OFFSET_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	input  logic [7:0]          text_byte,
	output logic                text_ready,
	input  logic                room,
	output bst_pkg::push_t      push
);

	localparam int WB = (OFFSET_BITS > 16) ? OFFSET_BITS : 17;
	localparam logic [OFFSET_BITS-1:0] OffMax = {OFFSET_BITS{1'b1}};

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	bst_pkg::mode_t         mode_q, mode_n;
	logic [OFFSET_BITS-1:0] start_q, start_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n, p1;
	logic                   adv;

	logic                   close_v, fresh, fresh_v;
	bst_pkg::kind_t         close_kind, fresh_kind;
	logic [OFFSET_BITS-1:0] close_after, fresh_after;

	// Offsets wider than the result field saturate at its top.
	function automatic logic [15:0] clip(input logic [OFFSET_BITS-1:0] v);
		logic [WB-1:0] e;
		e = WB'(v);
		return (|e[WB-1:16]) ? 16'hFFFF : e[15:0];
	endfunction

	// The stage moves on when the output queue can take two tokens.
	assign adv        = valid_s1 && room;
	assign text_ready = !valid_s1 || room;
	assign p1         = (pos_q == OffMax) ? pos_q : pos_q + 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			byte_s1 <= text_byte;
		end
	end

	// Scan state, updated once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bst_pkg::MODE_IDLE;
			start_q <= '0;
			pos_q   <= '0;
		end else if (adv) begin
			mode_q  <= mode_n;
			start_q <= start_n;
			pos_q   <= pos_n;
		end
	end

	// Close the pending run, then scan the byte fresh if it was not consumed.
	always_comb begin
		close_v     = 1'b0;
		close_kind  = bst_pkg::KIND_NUM;
		close_after = pos_q;
		fresh       = 1'b1;
		fresh_v     = 1'b0;
		fresh_kind  = bst_pkg::KIND_END;
		fresh_after = pos_q;
		mode_n      = mode_q;
		start_n     = start_q;

		unique case (mode_q)
			bst_pkg::MODE_NUM: begin
				if (bst_pkg::is_digit(byte_s1) || byte_s1 == bst_pkg::CHAR_DOT) begin
					fresh = 1'b0;
				end else begin
					close_v = 1'b1;
					close_kind = bst_pkg::KIND_NUM;
					mode_n = bst_pkg::MODE_IDLE;
				end
			end
			bst_pkg::MODE_WORD: begin
				if (bst_pkg::is_digit(byte_s1) || bst_pkg::is_alpha(byte_s1)) begin
					fresh = 1'b0;
				end else begin
					close_v = 1'b1;
					close_kind = bst_pkg::KIND_WORD;
					mode_n = bst_pkg::MODE_IDLE;
				end
			end
			bst_pkg::MODE_STR: begin
				close_kind = bst_pkg::KIND_STR;
				if (byte_s1 == bst_pkg::CHAR_QUOTE) begin
					close_v = 1'b1;
					close_after = p1;
					mode_n = bst_pkg::MODE_IDLE;
					fresh = 1'b0;
				end else if (byte_s1 == bst_pkg::CHAR_NUL) begin
					close_v = 1'b1;
					mode_n = bst_pkg::MODE_IDLE;
				end else begin
					fresh = 1'b0;
				end
			end
			bst_pkg::MODE_LT: begin
				close_v = 1'b1;
				close_kind = bst_pkg::KIND_OP;
				mode_n = bst_pkg::MODE_IDLE;
				if (byte_s1 == bst_pkg::CHAR_GT || byte_s1 == bst_pkg::CHAR_EQ) begin
					close_after = p1;
					fresh = 1'b0;
				end
			end
			bst_pkg::MODE_GT: begin
				close_v = 1'b1;
				close_kind = bst_pkg::KIND_OP;
				mode_n = bst_pkg::MODE_IDLE;
				if (byte_s1 == bst_pkg::CHAR_EQ) begin
					close_after = p1;
					fresh = 1'b0;
				end
			end
			default: begin
				mode_n = bst_pkg::MODE_IDLE;
			end
		endcase

		if (fresh) begin
			priority if (byte_s1 == bst_pkg::CHAR_NUL) begin
				fresh_v = 1'b1;
				fresh_kind = bst_pkg::KIND_END;
			end else if (bst_pkg::is_ws(byte_s1)) begin
				fresh_v = 1'b0;
			end else if (bst_pkg::is_digit(byte_s1) || byte_s1 == bst_pkg::CHAR_DOT) begin
				mode_n = bst_pkg::MODE_NUM;
				start_n = pos_q;
			end else if (bst_pkg::is_alpha(byte_s1)) begin
				mode_n = bst_pkg::MODE_WORD;
				start_n = pos_q;
			end else if (byte_s1 == bst_pkg::CHAR_QUOTE) begin
				mode_n = bst_pkg::MODE_STR;
				start_n = pos_q;
			end else if (byte_s1 == bst_pkg::CHAR_LT) begin
				mode_n = bst_pkg::MODE_LT;
				start_n = pos_q;
			end else if (byte_s1 == bst_pkg::CHAR_GT) begin
				mode_n = bst_pkg::MODE_GT;
				start_n = pos_q;
			end else begin
				fresh_v = 1'b1;
				fresh_kind = bst_pkg::KIND_CHAR;
				fresh_after = p1;
			end
		end

		// End of text restarts the position.
		if (byte_s1 == bst_pkg::CHAR_NUL) begin
			pos_n   = '0;
			start_n = '0;
			mode_n  = bst_pkg::MODE_IDLE;
		end else begin
			pos_n = p1;
		end
	end

	// Order the tokens: the closed run first, the fresh token second.
	always_comb begin
		push.v0 = adv && (close_v || fresh_v);
		push.v1 = adv && close_v && fresh_v;
		push.t1.kind  = fresh_kind;
		push.t1.first = clip(pos_q);
		push.t1.after = clip(fresh_after);
		push.t1.last  = 1'b1;
		if (close_v) begin
			push.t0.kind  = close_kind;
			push.t0.first = clip(start_q);
			push.t0.after = clip(close_after);
			push.t0.last  = !fresh_v;
		end else begin
			push.t0.kind  = fresh_kind;
			push.t0.first = clip(pos_q);
			push.t0.after = clip(fresh_after);
			push.t0.last  = 1'b1;
		end
	end

`ifndef ASSERT_OFF
	// A zero byte leaves the scanner idle at position zero.
	a_nul_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && byte_s1 == bst_pkg::CHAR_NUL |=> pos_q == '0 && mode_q == bst_pkg::MODE_IDLE)
		else $error("position not restarted after end of text");

	// A second token only follows a first one.
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0)
		else $error("second token without first");

	// Exactly the final token of a byte carries the last flag.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> (push.v1 ? (!push.t0.last && push.t1.last) : push.t0.last))
		else $error("last flag on the wrong token");

	// A saturated position stays saturated until end of text.
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pos_q == OffMax && byte_s1 != bst_pkg::CHAR_NUL |=> pos_q == OffMax)
		else $error("position wrapped");
`endif

endmodule

### rtl/bst_outq.sv
// ----------------------------------------------------------------------------
// bst_outq: output queue of the source tokenizer
// A small shifting queue that takes up to two tokens and gives one a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module bst_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  bst_pkg::push_t      push,
	output logic                room,
	bst_token_if.source         token
);

	localparam int Depth = bst_pkg::OUTQ_DEPTH;
	localparam int CntW  = bst_pkg::OUTQ_CNT_W;

	bst_pkg::token_t ent_q [Depth];
	bst_pkg::token_t sh [Depth];
	bst_pkg::token_t ent_n [Depth];
	logic [CntW-1:0] cnt_q, cnt_n, base;
	logic            pop;

	assign pop  = (cnt_q != '0) && token.ready;
	assign room = cnt_q <= CntW'(Depth - 2);
	assign base = cnt_q - CntW'(pop);

	// Shift on a pop, then write new tokens behind the survivors.
	always_comb begin
		for (int i = 0; i < Depth - 1; i++) begin
			sh[i] = pop ? ent_q[i + 1] : ent_q[i];
		end
		sh[Depth - 1] = ent_q[Depth - 1];
		for (int i = 0; i < Depth; i++) begin
			ent_n[i] = sh[i];
			if (push.v0 && base == CntW'(i)) begin
				ent_n[i] = push.t0;
			end
			if (push.v1 && base + 1'b1 == CntW'(i)) begin
				ent_n[i] = push.t1;
			end
		end
		cnt_n = base + CntW'(push.v0) + CntW'(push.v1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_n;
	end

	// The head entry drives the token channel.
	assign token.valid        = cnt_q != '0;
	assign token.token_kind   = ent_q[0].kind;
	assign token.token_first  = ent_q[0].first;
	assign token.token_after  = ent_q[0].after;
	assign token.final_of_run = ent_q[0].last;

endmodule

### rtl/basic_source_tokenizer.sv
// ----------------------------------------------------------------------------
// basic_source_tokenizer: streaming tokenizer for BASIC-like source text
// Reports token kinds and byte offsets for a stream of source bytes.
// ----------------------------------------------------------------------------
// When its input is not stalled, the block takes one source byte per cycle and
// reports each token as a transaction carrying its kind and the byte offsets
// of its first character and of the position just past it. A byte enters an
// input register and is scanned from it; its tokens are written into the
// output queue register and leave from the head of the queue. A byte that
// closes a run and also forms a token of its own gives two transactions;
// the four-entry output queue drains one token per cycle while the receiver
// is ready, so sustained throughput is one byte per cycle as long as tokens
// average no more than one per byte, and the input stalls while the queue
// holds more than two. A zero byte flushes any pending token, gives an end
// token and restarts the offsets at zero.
// ----------------------------------------------------------------------------
module basic_source_tokenizer #(
	parameter int OFFSET_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	bst_byte_if.sink      text,
	bst_token_if.source   token
);

	bst_pkg::push_t push;
	logic           room;

	// Scanner with its input register and scan state.
	bst_scan #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text.valid),
		.text_byte  (text.text_byte),
		.text_ready (text.ready),
		.room       (room),
		.push       (push)
	);

	// Output queue that splits two-token bytes over cycles.
	bst_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.token  (token)
	);

endmodule
